### hdl/whole_word_match_counter_assert.svh
// Assertion macros for the whole-word match counter.
// Used by the top level; depends on a clock named clk and a reset named rst.
`ifndef WHOLE_WORD_MATCH_COUNTER_ASSERT_SVH
`define WHOLE_WORD_MATCH_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WWMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("whole_word_match_counter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WWMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("whole_word_match_counter: next-cycle check failed");

`endif

### hdl/wwmc_pkg.sv
// Shared types and constants for the whole-word match counter.
// No dependencies; imported by the interfaces, the cell and the top level.
package wwmc_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2
  } opcode_t;

  // Field widths of the items.
  localparam int OpcodeWidth = 2;
  localparam int IndexWidth  = 7;
  localparam int CharWidth   = 8;
  localparam int LengthWidth = 8;
  localparam int ResultCountWidth = 32;

  // Word separators.
  localparam logic [CharWidth-1:0] CharSpace   = 8'h20;
  localparam logic [CharWidth-1:0] CharNewline = 8'h0A;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic                 load;   // pattern byte write
    logic                 shift;  // word byte: advance the match chain
    logic                 clear;  // separator or end of text: restart the word
    logic [IndexWidth-1:0] index;
    logic [CharWidth-1:0]  pchar;
    logic [CharWidth-1:0]  tchar;
  } cell_ctrl_t;

endpackage

### hdl/wwmc_in_if.sv
// Input channel of the whole-word match counter: valid, ready and item fields.
// Depends on wwmc_pkg.
interface wwmc_in_if import wwmc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpcodeWidth-1:0] opcode;
  logic [IndexWidth-1:0]  pattern_index;
  logic [CharWidth-1:0]   pattern_char;
  logic [CharWidth-1:0]   text_char;

  modport source (output valid, opcode, pattern_index, pattern_char, text_char,
                  input ready);
  modport sink (input valid, opcode, pattern_index, pattern_char, text_char,
                output ready);
endinterface

### hdl/wwmc_out_if.sv
// Result channel of the whole-word match counter: valid, ready and result fields.
// Depends on wwmc_pkg.
interface wwmc_out_if import wwmc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        word_matched;
  logic [ResultCountWidth-1:0] match_count;
  logic                        end_of_text;

  modport source (output valid, word_matched, match_count, end_of_text,
                  input ready);
  modport sink (input valid, word_matched, match_count, end_of_text,
                output ready);
endinterface

### hdl/wwmc_cell.sv
// One cell of the match chain: holds one pattern byte and one prefix-match bit.
// Depends on wwmc_pkg.
module wwmc_cell import wwmc_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       match_in,
  output logic       match_out
);

  localparam logic [LengthWidth-1:0] CellId = LengthWidth'(INDEX);

  logic [CharWidth-1:0] pattern_byte;
  logic                 match;

  // Pattern byte, written when a load item addresses this cell.
  always_ff @(posedge clk) begin
    if (ctrl.load && ({1'b0, ctrl.index} == CellId)) begin
      pattern_byte <= ctrl.pchar;
    end
  end

  // Match bit: the current word equals the first INDEX+1 pattern bytes.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.shift) begin
      match <= match_in && (pattern_byte == ctrl.tchar);
    end
  end

  assign match_out = match;

endmodule

### hdl/whole_word_match_counter.sv
// Whole-word match counter; an accepted item's result is registered for the next
// cycle. Throughput: one item per cycle unless the result side stalls; each cell
// compares one text byte per cycle; the result register frees once its result is
// taken. Reset clears the match chain, word state, count and result valid flag,
// sets the pattern length to 1. Pattern bytes are undefined until loaded.
module whole_word_match_counter import wwmc_pkg::*; #(
  parameter int PATTERN_MAX = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [LengthWidth-1:0] cfg_wr_data,
  wwmc_in_if.sink                req,
  wwmc_out_if.source             rsp
);

  `include "whole_word_match_counter_assert.svh"

  localparam logic [LengthWidth:0] PatternMaxLen = (LengthWidth + 1)'(PATTERN_MAX);

  logic [LengthWidth-1:0] pattern_length;
  logic                   word_empty;
  logic [LengthWidth-1:0] word_pos;
  logic                   word_bad;
  logic [COUNT_WIDTH-1:0] running_count;
  logic [COUNT_WIDTH-1:0] running_count_next;
  logic [PATTERN_MAX-1:0] match_vec;
  cell_ctrl_t             ctrl;

  logic                   accept;
  logic                   is_text;
  logic                   is_end;
  logic                   is_sep;
  logic                   len_ok;
  logic [LengthWidth-1:0] len_m1;
  logic                   tail_match;
  logic                   hit;
  logic [63:0]            count_wide;

  logic                        rsp_valid;
  logic                        rsp_valid_next;
  logic                        word_matched;
  logic                        word_matched_next;
  logic [ResultCountWidth-1:0] match_count;
  logic [ResultCountWidth-1:0] match_count_next;
  logic                        end_of_text;
  logic                        end_of_text_next;

  // Handshake: the result register takes a new item while its old one leaves.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Decode the accepted item.
  assign is_text = accept && (req.opcode == OP_TEXT);
  assign is_end  = accept && (req.opcode == OP_END);
  assign is_sep  = (req.text_char == CharSpace) || (req.text_char == CharNewline);

  assign ctrl.load  = accept && (req.opcode == OP_LOAD);
  assign ctrl.shift = is_text && !is_sep;
  assign ctrl.clear = (is_text && is_sep) || is_end;
  assign ctrl.index = req.pattern_index;
  assign ctrl.pchar = req.pattern_char;
  assign ctrl.tchar = req.text_char;

  // Chain of cells; the first cell starts a match only at the start of a word.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic link_in;
    if (i == 0) begin : g_head
      assign link_in = word_empty;
    end else begin : g_link
      assign link_in = match_vec[i-1];
    end
    wwmc_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .match_in (link_in),
      .match_out(match_vec[i])
    );
  end

  // Pick the match bit of the last pattern byte.
  assign len_ok = (pattern_length != '0) && ({1'b0, pattern_length} <= PatternMaxLen);
  assign len_m1 = pattern_length - LengthWidth'(1);

  always_comb begin
    tail_match = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (len_m1 == LengthWidth'(i)) begin
        tail_match = match_vec[i];
      end
    end
  end

  // A separator closing a full-length matching word is a hit.
  assign hit = is_text && is_sep && len_ok && tail_match && !word_bad;

  // Saturating count, cleared after end of text.
  always_comb begin
    running_count_next = running_count;
    if (hit && (running_count != '1)) begin
      running_count_next = running_count + COUNT_WIDTH'(1);
    end
  end

  assign count_wide = 64'(running_count_next);

  // Result register contents.
  always_comb begin
    rsp_valid_next    = rsp_valid && !rsp.ready;
    word_matched_next = word_matched;
    match_count_next  = match_count;
    end_of_text_next  = end_of_text;
    if (is_text || is_end) begin
      rsp_valid_next    = 1'b1;
      word_matched_next = hit;
      match_count_next  = count_wide[ResultCountWidth-1:0];
      end_of_text_next  = is_end;
    end
  end

  // Control and state registers. A word byte that arrives at or past the pattern
  // length, or while the length is out of range, spoils the word for good, even
  // if the length is changed before the word closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LengthWidth'(1);
      word_empty     <= 1'b1;
      word_pos       <= '0;
      word_bad       <= 1'b0;
      running_count  <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pattern_length <= cfg_wr_data;
      end
      if (ctrl.shift) begin
        word_empty <= 1'b0;
        if (word_pos != '1) begin
          word_pos <= word_pos + LengthWidth'(1);
        end
        if (!len_ok || (word_pos >= pattern_length)) begin
          word_bad <= 1'b1;
        end
      end else if (ctrl.clear) begin
        word_empty <= 1'b1;
        word_pos   <= '0;
        word_bad   <= 1'b0;
      end
      if (is_end) begin
        running_count <= '0;
      end else begin
        running_count <= running_count_next;
      end
      rsp_valid <= rsp_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    word_matched <= word_matched_next;
    match_count  <= match_count_next;
    end_of_text  <= end_of_text_next;
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.word_matched = word_matched;
  assign rsp.match_count  = match_count;
  assign rsp.end_of_text  = end_of_text;

  // A word has one length, so at most one cell can hold a prefix match.
  `WWMC_ASSERT_NOW(a_one_prefix, 1'b1, $onehot0(match_vec))
  // End of text restarts both the count and the word.
  `WWMC_ASSERT_NEXT(a_end_clears, is_end, (running_count == '0) && word_empty)
  // A pattern load yields no result.
  `WWMC_ASSERT_NEXT(a_load_silent, ctrl.load && !rsp_valid, !rsp_valid)
  // A final-count result never flags a match.
  `WWMC_ASSERT_NOW(a_end_no_hit, rsp_valid && end_of_text, !word_matched)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for whole_word_match_counter: streams pattern loads, text bytes and
// end-of-text items under random stalls and checks every result against a predictor.
// Depends on wwmc_pkg, wwmc_in_if, wwmc_out_if and the top level in hdl.
module tb;
  import wwmc_pkg::*;

  localparam int PatternMax   = 128;
  localparam int CountBits    = 32;
  localparam int LongStall    = 60;
  localparam int SettleCycles = 4;

  // Opcode that the block must ignore.
  localparam logic [OpcodeWidth-1:0] OpUnused = 2'd3;

  // One expected result.
  typedef struct packed {
    logic                        word_matched;
    logic [ResultCountWidth-1:0] match_count;
    logic                        end_of_text;
  } count_result_t;

  // Predicts the word and count state and checks results in order.
  class match_tracker;
    logic [CharWidth-1:0]   store_bytes [PatternMax];
    logic [LengthWidth-1:0] length;
    logic [7:0]             word_pos;
    bit                     word_ok;
    logic [CountBits-1:0]   count;
    count_result_t          expected_counts [$];
    int errors, items_seen, results_seen, matches_seen, ends_seen;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      length   = 8'd1;
      word_pos = '0;
      word_ok  = 1'b1;
      count    = '0;
    endfunction

    function void set_length(logic [LengthWidth-1:0] value);
      length = value;
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    // Updates the state for one accepted item and queues its result, if any.
    function void note_item(logic [OpcodeWidth-1:0] op, logic [IndexWidth-1:0] idx,
                            logic [CharWidth-1:0] pch, logic [CharWidth-1:0] tch);
      count_result_t r;
      bit len_ok;
      items_seen++;
      len_ok = (length >= 1) && (length <= PatternMax);
      r.word_matched = 1'b0;
      r.end_of_text  = 1'b0;
      r.match_count  = '0;
      case (op)
        OP_LOAD: store_bytes[idx] = pch;
        OP_TEXT: begin
          if (tch == CharSpace || tch == CharNewline) begin
            // A separator closes the word; only a full-length match counts.
            if (len_ok && word_pos != 0 && word_pos == length && word_ok) begin
              r.word_matched = 1'b1;
              if (count != '1) count++;
            end
            word_pos = '0;
            word_ok  = 1'b1;
          end else begin
            if (!len_ok || word_pos >= length || word_pos >= PatternMax ||
                store_bytes[word_pos] != tch)
              word_ok = 1'b0;
            if (word_pos != 8'hFF) word_pos++;
          end
          r.match_count = ResultCountWidth'(count);
          expected_counts.push_back(r);
        end
        OP_END: begin
          r.end_of_text = 1'b1;
          r.match_count = ResultCountWidth'(count);
          expected_counts.push_back(r);
          count    = '0;
          word_pos = '0;
          word_ok  = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic wm, logic [ResultCountWidth-1:0] cnt, logic eot);
      count_result_t e;
      results_seen++;
      if (expected_counts.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: word_matched=%0b match_count=%0d %s%0b",
                 $time, wm, cnt, "end_of_text=", eot);
        return;
      end
      e = expected_counts.pop_front();
      if (e.word_matched) matches_seen++;
      if (e.end_of_text) ends_seen++;
      if (wm !== e.word_matched) begin
        errors++;
        $display("%0t: word_matched expected %0b actual %0b", $time, e.word_matched, wm);
      end
      if (cnt !== e.match_count) begin
        errors++;
        $display("%0t: match_count expected %0d actual %0d", $time, e.match_count, cnt);
      end
      if (eot !== e.end_of_text) begin
        errors++;
        $display("%0t: end_of_text expected %0b actual %0b", $time, e.end_of_text, eot);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [LengthWidth-1:0] cfg_wr_data;

  wwmc_in_if  item_if ();
  wwmc_out_if result_if ();

  match_tracker         tracker;
  logic [CharWidth-1:0] loaded_pattern [PatternMax];
  bit                   quiet;
  bit                   hold_results;

  whole_word_match_counter #(
    .PATTERN_MAX (PatternMax),
    .COUNT_WIDTH (CountBits)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (item_if.sink),
    .rsp         (result_if.source)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both channels are sampled at the edge; results are checked before new items are noted.
  always @(posedge clk) begin : channel_monitor
    if (!rst) begin
      if (result_if.valid && result_if.ready)
        tracker.check_result(result_if.word_matched, result_if.match_count,
                             result_if.end_of_text);
      if (item_if.valid && item_if.ready)
        tracker.note_item(item_if.opcode, item_if.pattern_index, item_if.pattern_char,
                          item_if.text_char);
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin : result_pacing
    result_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        result_if.ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
        result_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin : run_limit
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Offers one item, with an occasional idle burst first, and waits until it is taken.
  task automatic send_item(input logic [OpcodeWidth-1:0] op,
                           input logic [IndexWidth-1:0] idx,
                           input logic [CharWidth-1:0] pch,
                           input logic [CharWidth-1:0] tch);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_if.valid         <= 1'b1;
    item_if.opcode        <= op;
    item_if.pattern_index <= idx;
    item_if.pattern_char  <= pch;
    item_if.text_char     <= tch;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  task automatic send_text(input logic [CharWidth-1:0] ch);
    send_item(OP_TEXT, 7'($urandom), 8'($urandom), ch);
  endtask

  task automatic send_load(input logic [IndexWidth-1:0] idx, input logic [CharWidth-1:0] ch);
    loaded_pattern[idx] = ch;
    send_item(OP_LOAD, idx, ch, 8'($urandom));
  endtask

  task automatic send_end();
    send_item(OP_END, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_item(OpUnused, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Random byte that is never a word separator.
  function automatic logic [CharWidth-1:0] word_byte();
    logic [CharWidth-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CharSpace || b == CharNewline);
    return b;
  endfunction

  function automatic logic [CharWidth-1:0] other_byte(input logic [CharWidth-1:0] b);
    logic [CharWidth-1:0] r;
    do r = word_byte(); while (r == b);
    return r;
  endfunction

  function automatic logic [CharWidth-1:0] separator();
    return ($urandom_range(0, 1) != 0) ? CharSpace : CharNewline;
  endfunction

  // Sends the first nbytes of the loaded pattern, one byte altered at bad_pos,
  // followed by extra random word bytes.
  task automatic send_pattern_word(input int nbytes, input int bad_pos, input int extra);
    logic [CharWidth-1:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = loaded_pattern[i];
      if (i == bad_pos) b = other_byte(b);
      send_text(b);
    end
    repeat (extra) send_text(word_byte());
  endtask

  // One random step of text: mostly words built around the pattern, some noise.
  task automatic send_random_word(input int plen);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) send_end();
    else if (pick < 9) send_noise();
    else if (pick < 12) send_load(7'($urandom_range(0, PatternMax - 1)), word_byte());
    else begin
      if (pick < 50) send_pattern_word(plen, -1, 0);
      else if (pick < 62 && plen > 1) send_pattern_word($urandom_range(1, plen - 1), -1, 0);
      else if (pick < 74) send_pattern_word(plen, $urandom_range(0, plen - 1), 0);
      else if (pick < 84) send_pattern_word(plen, -1, $urandom_range(1, 3));
      else send_pattern_word(0, -1, $urandom_range(1, 6));
      // Usually one separator, sometimes none or two.
      if ($urandom_range(0, 19) != 0) send_text(separator());
      if ($urandom_range(0, 4) == 0) send_text(separator());
    end
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_length(input logic [LengthWidth-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_length(len);
  endtask

  // New length, a fresh pattern of that size (1 to 6 if out of range), then random text.
  task automatic run_phase(input logic [LengthWidth-1:0] len, input int words);
    int plen;
    wait_idle();
    write_length(len);
    plen = (len >= 1 && len <= PatternMax) ? int'(len) : $urandom_range(1, 6);
    for (int i = 0; i < plen; i++) send_load(7'(i), word_byte());
    repeat (words) send_random_word(plen);
  endtask

  // Main stimulus.
  initial begin : stimulus
    tracker               = new();
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    item_if.valid         = 1'b0;
    item_if.opcode        = OP_LOAD;
    item_if.pattern_index = '0;
    item_if.pattern_char  = '0;
    item_if.text_char     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole pattern store so no unwritten entry is ever compared.
    for (int i = 0; i < PatternMax; i++) send_load(7'(i), word_byte());

    // Directed checks at the reset length of one byte.
    send_load(7'd0, 8'hFF);
    send_text(8'hFF);
    send_text(CharSpace);
    // Back-to-back separators close only empty words.
    send_text(CharSpace);
    send_text(CharNewline);
    // A newline closes a word just like a space.
    send_text(8'hFF);
    send_text(CharNewline);
    // Too long, then the wrong byte.
    send_text(8'hFF);
    send_text(8'hFF);
    send_text(CharSpace);
    send_text(8'h00);
    send_text(CharSpace);
    send_load(7'd127, 8'h00);
    send_noise();
    // A word still open at end of text is not counted, and end of text clears it.
    send_text(8'hFF);
    send_end();
    send_text(CharSpace);
    send_end();

    // Random text under a range of pattern lengths.
    run_phase(8'd3, 6);
    run_phase(8'd1, 6);

    // Longest pattern, using the bytes already held in the store.
    wait_idle();
    write_length(8'(PatternMax));
    send_pattern_word(PatternMax, -1, 0);
    send_text(CharSpace);
    send_end();

    // Lengths that can never match.
    run_phase(8'd0, 3);
    run_phase(8'd255, 3);
    run_phase(8'(PatternMax + 1), 2);

    // Long hold-off on the result side while items keep coming.
    run_phase(8'd7, 2);
    hold_results = 1'b1;
    repeat (4) send_random_word(7);

    // Sender pause until everything has drained, mid-text.
    run_phase(8'd2, 5);
    wait_idle();
    repeat (5) send_random_word(2);

    // Last stretch without any idling.
    wait_idle();
    quiet = 1'b1;
    run_phase(8'd5, 5);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d items: %0d whole-word matches, %0d final counts.",
             tracker.results_seen, tracker.items_seen, tracker.matches_seen, tracker.ends_seen);
    $display("Pattern lengths between 0 and 255 were used, with stall bursts on both channels.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
